/* rtl/gmd_pkg.sv */
// shared types, constants and helpers for the grid maze depth-first solver
// used by every module under rtl; depends on nothing else
package gmd_pkg;

    localparam int GRID_WIDTH  = 16;
    localparam int GRID_HEIGHT = 16;
    localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;

    localparam int COL_W  = $clog2(GRID_WIDTH);
    localparam int ROW_W  = $clog2(GRID_HEIGHT);
    localparam int CELL_W = $clog2(CELL_COUNT);
    localparam int SP_W   = CELL_W + 1;
    localparam int GOAL_W = 4;
    localparam int WALL_W = 4;

    // register indexes of the configuration port
    typedef enum logic [0:0] {
        CFG_GOAL_COLUMN = 1'b0,
        CFG_GOAL_ROW    = 1'b1
    } cfg_index_t;

    // action codes, code 3 is reserved
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_SOLVE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // search directions, in the order they are tried
    localparam logic [2:0] DIR_LEFT  = 3'd0;
    localparam logic [2:0] DIR_RIGHT = 3'd1;
    localparam logic [2:0] DIR_UP    = 3'd2;
    localparam logic [2:0] DIR_DOWN  = 3'd3;
    localparam logic [2:0] DIR_DONE  = 3'd4;

    // wall bit positions
    localparam int WALL_LEFT   = 0;
    localparam int WALL_RIGHT  = 1;
    localparam int WALL_TOP    = 2;
    localparam int WALL_BOTTOM = 3;

    typedef struct packed {
        logic [1:0]        action;
        logic [7:0]        cell_index;
        logic [WALL_W-1:0] wall_bits;
    } in_item_t;

    typedef struct packed {
        logic found;
        logic on_path;
        logic cell_visited;
    } out_item_t;

    // one cell memory word
    typedef struct packed {
        logic [WALL_W-1:0] walls;
        logic              visited;
        logic              path;
    } cell_word_t;

    // cell memory write with one enable per field
    typedef struct packed {
        logic              en_walls;
        logic              en_visited;
        logic              en_path;
        logic [CELL_W-1:0] addr;
        cell_word_t        data;
    } cell_wr_t;

    // a stack frame below the top; dir holds the next direction minus one
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [1:0]       dir;
    } frame_t;

    typedef struct packed {
        logic              we;
        logic [CELL_W-1:0] waddr;
        frame_t            wdata;
        logic              re;
        logic [CELL_W-1:0] raddr;
    } stack_req_t;

    function automatic logic [CELL_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] row);
        return CELL_W'(int'(row) * GRID_WIDTH + int'(col));
    endfunction

endpackage

/* rtl/gmd_cell_ram.sv */
// cell memory: walls, visited mark and path mark of every maze cell
// one write port with per-field enables, one registered read port; uses gmd_pkg
module gmd_cell_ram (
    input  logic                        clk,
    input  gmd_pkg::cell_wr_t           wr,
    input  logic                        rd_en,
    input  logic [gmd_pkg::CELL_W-1:0]  rd_addr,
    output gmd_pkg::cell_word_t         rd_data
);
    import gmd_pkg::*;

    cell_word_t mem [CELL_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr.en_walls)
        begin
            mem[wr.addr].walls <= wr.data.walls;
        end
        if (wr.en_visited)
        begin
            mem[wr.addr].visited <= wr.data.visited;
        end
        if (wr.en_path)
        begin
            mem[wr.addr].path <= wr.data.path;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/gmd_stack_ram.sv */
// search stack memory: frames below the top of the depth-first stack
// one write port, one registered read port; uses gmd_pkg
module gmd_stack_ram (
    input  logic                clk,
    input  gmd_pkg::stack_req_t req,
    output gmd_pkg::frame_t     rd_data
);
    import gmd_pkg::*;

    frame_t mem [CELL_COUNT];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule

/* rtl/gmd_search.sv */
// item sequencer: load, read, clearing sweeps and the depth-first search
// owns the cell and stack memories; uses gmd_pkg, gmd_cell_ram, gmd_stack_ram
module gmd_search (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  gmd_pkg::in_item_t         item,
    input  logic [gmd_pkg::GOAL_W-1:0] goal_col,
    input  logic [gmd_pkg::GOAL_W-1:0] goal_row,
    output logic                      res_valid,
    input  logic                      res_take,
    output gmd_pkg::out_item_t        res
);
    import gmd_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_START,
        S_WALLS,
        S_SEARCH,
        S_CHECK,
        S_POP_WAIT,
        S_MARK_TOP,
        S_MARK_RD,
        S_MARK_WR,
        S_RESULT
    } state_t;

    state_t            state_reg, state_next;
    logic [CELL_W-1:0] clr_reg, clr_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [SP_W-1:0]   walk_reg, walk_next;
    logic [COL_W-1:0]  top_col_reg, top_col_next;
    logic [ROW_W-1:0]  top_row_reg, top_row_next;
    logic [2:0]        top_dir_reg, top_dir_next;
    logic [WALL_W-1:0] top_walls_reg, top_walls_next;
    logic [COL_W-1:0]  nxt_col_reg, nxt_col_next;
    logic [ROW_W-1:0]  nxt_row_reg, nxt_row_next;
    out_item_t         res_reg, res_next;

    cell_wr_t          cell_wr;
    logic              cell_rd_en;
    logic [CELL_W-1:0] cell_rd_addr;
    cell_word_t        cell_rd_data;
    stack_req_t        stk;
    frame_t            stk_rd_data;

    logic              move_open;
    logic [COL_W-1:0]  move_col;
    logic [ROW_W-1:0]  move_row;
    logic              move_goal;
    logic              idx_ok;

    gmd_cell_ram u_cell_ram (
        .clk     (clk),
        .wr      (cell_wr),
        .rd_en   (cell_rd_en),
        .rd_addr (cell_rd_addr),
        .rd_data (cell_rd_data)
    );

    gmd_stack_ram u_stack_ram (
        .clk     (clk),
        .req     (stk),
        .rd_data (stk_rd_data)
    );

    assign idx_ok = (32'(item.cell_index) < CELL_COUNT);

    // neighbor in the current direction of the top frame
    always_comb
    begin
        move_open = 1'b0;
        move_col  = top_col_reg;
        move_row  = top_row_reg;
        unique case (top_dir_reg)
            DIR_LEFT:
            begin
                move_open = (top_col_reg != '0) && !top_walls_reg[WALL_LEFT];
                move_col  = top_col_reg - COL_W'(1);
            end
            DIR_RIGHT:
            begin
                move_open = (top_col_reg != COL_W'(GRID_WIDTH - 1))
                            && !top_walls_reg[WALL_RIGHT];
                move_col  = top_col_reg + COL_W'(1);
            end
            DIR_UP:
            begin
                move_open = (top_row_reg != '0) && !top_walls_reg[WALL_TOP];
                move_row  = top_row_reg - ROW_W'(1);
            end
            DIR_DOWN:
            begin
                move_open = (top_row_reg != ROW_W'(GRID_HEIGHT - 1))
                            && !top_walls_reg[WALL_BOTTOM];
                move_row  = top_row_reg + ROW_W'(1);
            end
            default:
            begin
                move_open = 1'b0;
            end
        endcase
        move_goal = (32'(goal_col) == 32'(move_col)) && (32'(goal_row) == 32'(move_row));
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        sp_next        = sp_reg;
        walk_next      = walk_reg;
        top_col_next   = top_col_reg;
        top_row_next   = top_row_reg;
        top_dir_next   = top_dir_reg;
        top_walls_next = top_walls_reg;
        nxt_col_next   = nxt_col_reg;
        nxt_row_next   = nxt_row_reg;
        res_next       = res_reg;

        cell_wr      = '0;
        cell_rd_en   = 1'b0;
        cell_rd_addr = cell_addr(top_col_reg, top_row_reg);
        stk          = '0;

        item_ready = (state_reg == S_IDLE);
        res_valid  = (state_reg == S_RESULT);

        unique case (state_reg)
            S_INIT:
            begin
                // sweep after reset: all visited and path marks to zero
                cell_wr.en_visited = 1'b1;
                cell_wr.en_path    = 1'b1;
                cell_wr.addr       = clr_reg;
                clr_next           = clr_reg + CELL_W'(1);
                if (clr_reg == CELL_W'(CELL_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                res_next = '0;
                if (item_valid)
                begin
                    unique case (item.action)
                        ACT_LOAD:
                        begin
                            cell_wr.en_walls   = idx_ok;
                            cell_wr.en_path    = idx_ok;
                            cell_wr.addr       = CELL_W'(item.cell_index);
                            cell_wr.data.walls = item.wall_bits;
                            state_next         = S_RESULT;
                        end
                        ACT_SOLVE:
                        begin
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        ACT_READ:
                        begin
                            cell_rd_en   = idx_ok;
                            cell_rd_addr = CELL_W'(item.cell_index);
                            state_next   = idx_ok ? S_READ : S_RESULT;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_next.on_path      = cell_rd_data.path;
                res_next.cell_visited = cell_rd_data.visited;
                state_next            = S_RESULT;
            end
            S_CLEAR:
            begin
                cell_wr.en_visited = 1'b1;
                cell_wr.addr       = clr_reg;
                clr_next           = clr_reg + CELL_W'(1);
                if (clr_reg == CELL_W'(CELL_COUNT - 1))
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cell_wr.addr = '0;
                if ((goal_col == '0) && (goal_row == '0))
                begin
                    cell_wr.en_path   = 1'b1;
                    cell_wr.data.path = 1'b1;
                    res_next.found    = 1'b1;
                    sp_next           = '0;
                    state_next        = S_RESULT;
                end
                else
                begin
                    // only the walls lane is used from this read
                    cell_wr.en_visited   = 1'b1;
                    cell_wr.data.visited = 1'b1;
                    cell_rd_en           = 1'b1;
                    cell_rd_addr         = '0;
                    top_col_next         = '0;
                    top_row_next         = '0;
                    top_dir_next         = DIR_LEFT;
                    sp_next              = SP_W'(1);
                    state_next           = S_WALLS;
                end
            end
            S_WALLS:
            begin
                top_walls_next = cell_rd_data.walls;
                state_next     = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (top_dir_reg == DIR_DONE)
                begin
                    if (sp_reg == SP_W'(1))
                    begin
                        sp_next        = '0;
                        res_next.found = 1'b0;
                        state_next     = S_RESULT;
                    end
                    else
                    begin
                        stk.re     = 1'b1;
                        stk.raddr  = CELL_W'(sp_reg - SP_W'(2));
                        sp_next    = sp_reg - SP_W'(1);
                        state_next = S_POP_WAIT;
                    end
                end
                else
                begin
                    top_dir_next = top_dir_reg + 3'd1;
                    if (move_open)
                    begin
                        if (move_goal)
                        begin
                            cell_wr.en_path   = 1'b1;
                            cell_wr.addr      = cell_addr(move_col, move_row);
                            cell_wr.data.path = 1'b1;
                            state_next        = S_MARK_TOP;
                        end
                        else
                        begin
                            cell_rd_en   = 1'b1;
                            cell_rd_addr = cell_addr(move_col, move_row);
                            nxt_col_next = move_col;
                            nxt_row_next = move_row;
                            state_next   = S_CHECK;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                state_next = S_SEARCH;
                if (!cell_rd_data.visited)
                begin
                    cell_wr.en_visited   = 1'b1;
                    cell_wr.addr         = cell_addr(nxt_col_reg, nxt_row_reg);
                    cell_wr.data.visited = 1'b1;
                    // a full stack drops the push, the cell stays marked
                    if (32'(sp_reg) < CELL_COUNT)
                    begin
                        stk.we         = 1'b1;
                        stk.waddr      = CELL_W'(sp_reg - SP_W'(1));
                        stk.wdata.col  = top_col_reg;
                        stk.wdata.row  = top_row_reg;
                        stk.wdata.dir  = 2'(top_dir_reg - 3'd1);
                        top_col_next   = nxt_col_reg;
                        top_row_next   = nxt_row_reg;
                        top_dir_next   = DIR_LEFT;
                        top_walls_next = cell_rd_data.walls;
                        sp_next        = sp_reg + SP_W'(1);
                    end
                end
            end
            S_POP_WAIT:
            begin
                top_col_next = stk_rd_data.col;
                top_row_next = stk_rd_data.row;
                top_dir_next = {1'b0, stk_rd_data.dir} + 3'd1;
                cell_rd_en   = 1'b1;
                cell_rd_addr = cell_addr(stk_rd_data.col, stk_rd_data.row);
                state_next   = S_WALLS;
            end
            S_MARK_TOP:
            begin
                cell_wr.en_path   = 1'b1;
                cell_wr.addr      = cell_addr(top_col_reg, top_row_reg);
                cell_wr.data.path = 1'b1;
                walk_next         = '0;
                state_next        = S_MARK_RD;
            end
            S_MARK_RD:
            begin
                if (walk_reg == sp_reg - SP_W'(1))
                begin
                    res_next.found = 1'b1;
                    state_next     = S_RESULT;
                end
                else
                begin
                    stk.re     = 1'b1;
                    stk.raddr  = walk_reg[CELL_W-1:0];
                    state_next = S_MARK_WR;
                end
            end
            S_MARK_WR:
            begin
                cell_wr.en_path   = 1'b1;
                cell_wr.addr      = cell_addr(stk_rd_data.col, stk_rd_data.row);
                cell_wr.data.path = 1'b1;
                walk_next         = walk_reg + SP_W'(1);
                state_next        = S_MARK_RD;
            end
            S_RESULT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            clr_reg     <= '0;
            sp_reg      <= '0;
            walk_reg    <= '0;
            top_dir_reg <= DIR_LEFT;
            res_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            sp_reg      <= sp_next;
            walk_reg    <= walk_next;
            top_dir_reg <= top_dir_next;
            res_reg     <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_col_reg   <= top_col_next;
        top_row_reg   <= top_row_next;
        top_walls_reg <= top_walls_next;
        nxt_col_reg   <= nxt_col_next;
        nxt_row_reg   <= nxt_row_next;
    end

    a_push_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        stk.we |-> ((32'(sp_reg) < CELL_COUNT)
                    && (stk.waddr == CELL_W'(sp_reg - SP_W'(1)))))
        else $error("stack push outside the frames in use");

    a_stack_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(stk.we && stk.re))
        else $error("stack read and write in the same cycle");

    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        top_dir_reg <= DIR_DONE)
        else $error("top frame direction out of range");

    a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && (item.action == ACT_SOLVE)) |=> !item_ready)
        else $error("new beat taken while a solve runs");

endmodule

/* rtl/grid_maze_dfs_path_solver.sv */
// Grid maze path solver, depth-first, 16 x 16 cells.
// in channel (in_valid/in_ready/in_data): one beat is a load, a solve or a read.
//   load writes a cell's walls and clears its path mark; result beat all zero
//   solve clears every visited mark, searches from cell (0,0) to the goal
//   and marks the route; result beat carries found
//   read returns the path and visited marks of one cell
// out channel (out_valid/out_ready/out_data): exactly one result beat per item.
// cfg port: goal_column at index 0, goal_row at index 1, written on cfg_write_en;
//   write only while no item is in flight.
// a solve first clears every visited mark, then sets up the start cell, then runs
//   the search on the cell and stack memories, trying each direction of the top
//   frame, pushing open unvisited neighbours and popping exhausted frames, then
//   marks the route cells when the goal is reached.
// items are handled one at a time; the next item is taken while a result beat
//   waits in the output register, so a stalled receiver holds that beat and at most one more.
// after reset a clearing pass zeroes all marks with in_ready low;
//   config writes are taken throughout. goal registers reset to (15, 15).
// depends on gmd_pkg and gmd_search
module grid_maze_dfs_path_solver (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  gmd_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output gmd_pkg::out_item_t          out_data,
    input  logic                        cfg_write_en,
    input  logic [0:0]                  cfg_index,
    input  logic [gmd_pkg::GOAL_W-1:0]  cfg_data
);
    import gmd_pkg::*;

    logic [GOAL_W-1:0] goal_col_reg, goal_col_next;
    logic [GOAL_W-1:0] goal_row_reg, goal_row_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic              res_valid;
    logic              res_take;
    out_item_t         res;

    gmd_search u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid),
        .item_ready (in_ready),
        .item       (in_data),
        .goal_col   (goal_col_reg),
        .goal_row   (goal_row_reg),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res)
    );

    assign res_take = !out_valid_reg || out_ready;

    always_comb
    begin
        goal_col_next = goal_col_reg;
        goal_row_next = goal_row_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GOAL_COLUMN: goal_col_next = cfg_data;
                CFG_GOAL_ROW:    goal_row_next = cfg_data;
                default:         goal_col_next = goal_col_reg;
            endcase
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_col_reg  <= GOAL_W'(15);
            goal_row_reg  <= GOAL_W'(15);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            goal_col_reg  <= goal_col_next;
            goal_row_reg  <= goal_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
